/* src/clns_pkg.sv */
// ----------------------------------------------------------------------------
// clns_pkg
// Shared types, constants and helpers of the character LCD nibble sequencer.
// ----------------------------------------------------------------------------
package clns_pkg;

  // Command codes carried by an input item
  typedef enum logic [1:0] {
    OP_INIT   = 2'd0,
    OP_CHAR   = 2'd1,
    OP_CURSOR = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_POWER_ON_WAIT = 2'd0;
  localparam logic [1:0] REG_LONG_WAIT     = 2'd1;
  localparam logic [1:0] REG_SHORT_WAIT    = 2'd2;
  localparam logic [1:0] REG_WRAP_COLUMN   = 2'd3;

  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;

  // Register reset values
  localparam logic [7:0] POWER_ON_WAIT_RST = 8'd100;
  localparam logic [7:0] LONG_WAIT_RST     = 8'd20;
  localparam logic [7:0] SHORT_WAIT_RST    = 8'd1;
  localparam logic [4:0] WRAP_COLUMN_RST   = 5'd8;

  // LCD command bytes and limits
  localparam logic [7:0] CURSOR_LINE1 = 8'h80;
  localparam logic [7:0] CURSOR_LINE2 = 8'hC0;
  localparam logic [7:0] CLEAR_CMD    = 8'h01;
  localparam logic [4:0] COUNT_MAX    = 5'd31;
  localparam logic [3:0] INIT_LAST    = 4'd13;

  // Depth of the command queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef struct packed {
    op_e        op;
    logic [7:0] char_code;
    logic       line_two;
    logic       word_start;
  } in_item_t;

  typedef struct packed {
    logic       reg_select;
    logic [3:0] nibble;
    logic [7:0] wait_before_ms;
    logic [7:0] wait_after_ms;
    logic       last;
  } out_item_t;

  // Configuration register set
  typedef struct packed {
    logic [7:0] power_on_wait_ms;
    logic [7:0] long_wait_ms;
    logic [7:0] short_wait_ms;
    logic [4:0] wrap_column;
  } cfg_t;

  // Classified command handed from front to back
  typedef struct packed {
    op_e        op;
    logic       wrap;  // move cursor to line two before the character
    logic [7:0] data;  // character byte or cursor command byte
  } desc_t;

  // Power-on init nibble series
  function automatic logic [3:0] init_nibble(input logic [3:0] step);
    logic [3:0] nib;
    case (step)
      4'd0, 4'd1, 4'd2: nib = 4'h3;
      4'd3, 4'd4:       nib = 4'h2;
      4'd5, 4'd7:       nib = 4'h8;
      4'd9:             nib = 4'h1;
      4'd11:            nib = 4'h6;
      4'd13:            nib = 4'hF;
      default:          nib = 4'h0;
    endcase
    return nib;
  endfunction

endpackage

/* src/clns_front.sv */
// ----------------------------------------------------------------------------
// clns_front
// Accepts command items, tracks the word character count and classifies
// each command into a descriptor for the back end.
// ----------------------------------------------------------------------------
module clns_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  clns_pkg::cfg_t    cfg_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  clns_pkg::in_item_t in_data_i,
  output logic              push_valid_o,
  input  logic              push_ready_i,
  output clns_pkg::desc_t   push_data_o
);

  logic [4:0] count_q, count_d;
  logic [4:0] base;
  logic       accept;

  assign in_ready_o   = push_ready_i;
  assign push_valid_o = in_valid_i;
  assign accept       = in_valid_i && push_ready_i;

  // Restart the count on the first character of a word
  assign base = in_data_i.word_start ? 5'd0 : count_q;

  // Build the descriptor
  always_comb begin
    push_data_o.op   = in_data_i.op;
    push_data_o.wrap = 1'b0;
    push_data_o.data = 8'h00;
    case (in_data_i.op)
      clns_pkg::OP_CHAR: begin
        push_data_o.wrap = (base == cfg_i.wrap_column);
        push_data_o.data = in_data_i.char_code;
      end
      clns_pkg::OP_CURSOR: begin
        push_data_o.data = in_data_i.line_two ? clns_pkg::CURSOR_LINE2
                                              : clns_pkg::CURSOR_LINE1;
      end
      default: begin
        push_data_o.data = 8'h00;
      end
    endcase
  end

  // Advance the count on characters, hold at the maximum
  always_comb begin
    count_d = count_q;
    if (accept && (in_data_i.op == clns_pkg::OP_CHAR)) begin
      count_d = (base == clns_pkg::COUNT_MAX) ? base : base + 5'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 5'd0;
    end else begin
      count_q <= count_d;
    end
  end

endmodule

/* src/clns_queue.sv */
// ----------------------------------------------------------------------------
// clns_queue
// Small FIFO of command descriptors between front and back end.
// ----------------------------------------------------------------------------
module clns_queue #(
  parameter int unsigned Depth = clns_pkg::QUEUE_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  clns_pkg::desc_t push_data_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output clns_pkg::desc_t pop_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] Full    = CntW'(Depth);

  clns_pkg::desc_t entry_q [Depth];
  logic [PtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;

  assign push_ready_o = (cnt_q != Full);
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = entry_q[rptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Advance pointers with wrap, track fill level
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push) begin
      wptr_d = (wptr_q == LastPtr) ? '0 : wptr_q + 1'b1;
    end
    if (pop) begin
      rptr_d = (rptr_q == LastPtr) ? '0 : rptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Store descriptors
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wptr_q] <= push_data_i;
    end
  end

endmodule

/* src/clns_back.sv */
// ----------------------------------------------------------------------------
// clns_back
// Steps through the nibble transfers of the descriptor at the queue head and
// loads them into the output register one per cycle while the output is not held.
// ----------------------------------------------------------------------------
module clns_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  clns_pkg::cfg_t      cfg_i,
  input  logic                pop_valid_i,
  output logic                pop_ready_o,
  input  clns_pkg::desc_t     pop_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output clns_pkg::out_item_t out_data_o
);

  logic [3:0]          step_q, step_d;
  logic [3:0]          final_step;
  logic                is_last, load;
  logic                out_valid_q, out_valid_d;
  clns_pkg::out_item_t out_q, item;

  // Last step of each command
  always_comb begin
    case (pop_data_i.op)
      clns_pkg::OP_INIT: final_step = clns_pkg::INIT_LAST;
      clns_pkg::OP_CHAR: final_step = pop_data_i.wrap ? 4'd3 : 4'd1;
      default:           final_step = 4'd1;
    endcase
  end

  assign is_last = (step_q == final_step);
  assign load    = pop_valid_i && (!out_valid_q || out_ready_i);
  assign pop_ready_o = load && is_last;

  // Form the transfer for the current step
  always_comb begin
    item.reg_select     = 1'b0;
    item.nibble         = 4'h0;
    item.wait_before_ms = 8'd0;
    item.wait_after_ms  = cfg_i.long_wait_ms;
    item.last           = is_last;
    case (pop_data_i.op)
      clns_pkg::OP_INIT: begin
        item.nibble = clns_pkg::init_nibble(step_q);
        if (step_q == 4'd0) begin
          item.wait_before_ms = cfg_i.power_on_wait_ms;
        end
      end
      clns_pkg::OP_CHAR: begin
        if (pop_data_i.wrap && !step_q[1]) begin
          // line-two cursor move ahead of the character
          item.nibble        = step_q[0] ? clns_pkg::CURSOR_LINE2[3:0]
                                         : clns_pkg::CURSOR_LINE2[7:4];
          item.wait_after_ms = step_q[0] ? cfg_i.short_wait_ms : cfg_i.long_wait_ms;
        end else begin
          item.reg_select    = 1'b1;
          item.nibble        = step_q[0] ? pop_data_i.data[3:0] : pop_data_i.data[7:4];
          item.wait_after_ms = cfg_i.short_wait_ms;
        end
      end
      clns_pkg::OP_CURSOR: begin
        item.nibble        = step_q[0] ? pop_data_i.data[3:0] : pop_data_i.data[7:4];
        item.wait_after_ms = step_q[0] ? cfg_i.short_wait_ms : cfg_i.long_wait_ms;
      end
      default: begin
        item.nibble = step_q[0] ? clns_pkg::CLEAR_CMD[3:0] : clns_pkg::CLEAR_CMD[7:4];
      end
    endcase
  end

  // Advance the step, drop the valid once the item is taken
  always_comb begin
    step_d      = step_q;
    out_valid_d = out_valid_q;
    if (load) begin
      step_d      = is_last ? 4'd0 : step_q + 4'd1;
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= 4'd0;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the transfer until taken
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= item;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* src/char_lcd_nibble_sequencer.sv */
// ----------------------------------------------------------------------------
// char_lcd_nibble_sequencer
// Turns LCD commands into the 4-bit nibble transfers of a character LCD.
// ----------------------------------------------------------------------------
// Usage:
//   Command items (init, write character, set cursor line, clear) enter on
//   the in_* valid/ready channel. Each produces a series of transfers on the
//   out_* channel: register select, nibble, wait before and after the enable
//   strobe, and a last flag on the final transfer of the command.
//   Init gives 14 transfers, a character 2 (or 4 when it wraps to line
//   two), set cursor line and clear 2 each.
//   When the block is empty, an accepted item is written into the queue and
//   its first transfer is then loaded into the back end's output register.
//   Throughput is one transfer per cycle while out_ready_i does not hold the
//   output, set by the back-end step counter. A two-entry queue lets the front
//   keep taking items while the back end works.
//   When out_ready_i is low the output register holds its transfer, the back
//   end stops, and once the queue fills in_ready_o falls.
//   Reset clears the queue, the word character count and the output valid,
//   and loads the register defaults. APB registers sit at byte addresses 0,
//   4, 8, 12; the user writes them only while the block is idle (not enforced).
// ----------------------------------------------------------------------------
module char_lcd_nibble_sequencer #(
  parameter int unsigned QueueDepth = clns_pkg::QUEUE_DEPTH
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [clns_pkg::PADDR_W-1:0] paddr,
  input  logic [clns_pkg::PDATA_W-1:0] pwdata,
  output logic [clns_pkg::PDATA_W-1:0] prdata,
  output logic                         pready,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  clns_pkg::in_item_t           in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output clns_pkg::out_item_t          out_data_o
);

  clns_pkg::cfg_t  cfg_q, cfg_d;
  logic [1:0]      reg_idx;
  logic            cfg_write;
  logic            push_valid, push_ready, pop_valid, pop_ready;
  clns_pkg::desc_t push_data, pop_data;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[3:2];
  assign cfg_write = psel && penable && pwrite && pready;

  // Register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_write) begin
      case (reg_idx)
        clns_pkg::REG_POWER_ON_WAIT: cfg_d.power_on_wait_ms = pwdata[7:0];
        clns_pkg::REG_LONG_WAIT:     cfg_d.long_wait_ms     = pwdata[7:0];
        clns_pkg::REG_SHORT_WAIT:    cfg_d.short_wait_ms    = pwdata[7:0];
        default:                     cfg_d.wrap_column      = pwdata[4:0];
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (reg_idx)
      clns_pkg::REG_POWER_ON_WAIT: prdata = {24'd0, cfg_q.power_on_wait_ms};
      clns_pkg::REG_LONG_WAIT:     prdata = {24'd0, cfg_q.long_wait_ms};
      clns_pkg::REG_SHORT_WAIT:    prdata = {24'd0, cfg_q.short_wait_ms};
      default:                     prdata = {27'd0, cfg_q.wrap_column};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.power_on_wait_ms <= clns_pkg::POWER_ON_WAIT_RST;
      cfg_q.long_wait_ms     <= clns_pkg::LONG_WAIT_RST;
      cfg_q.short_wait_ms    <= clns_pkg::SHORT_WAIT_RST;
      cfg_q.wrap_column      <= clns_pkg::WRAP_COLUMN_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  clns_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  clns_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  clns_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
